### hw/rtl/ird_pkg.sv
package ird_pkg;

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int SAMPLE_W    = 10;
   localparam int STATUS_W    = 2;
   localparam int CODE_W      = 3;
   localparam int LEVEL_W     = 10;
   localparam int GAP_W       = 12;
   localparam int TIMEOUT_W   = 16;
   localparam int LENGTH_W    = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   // Register reset values
   localparam logic [LEVEL_W-1:0]   LEVEL_THRESHOLD_RST = 10'd25;
   localparam logic [GAP_W-1:0]     GAP_THRESHOLD_RST   = 12'd15;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST      = 16'd200;
   localparam logic [LENGTH_W-1:0]  CAPTURE_LENGTH_RST  = 12'd500;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL_THRESHOLD = 2'd0,
      CSR_GAP_THRESHOLD   = 2'd1,
      CSR_TIMEOUT_MS      = 2'd2,
      CSR_CAPTURE_LENGTH  = 2'd3
   } csr_index_type;

   // Request kinds
   typedef enum logic [ACTION_W-1:0] {
      ACT_START  = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_TIMEOUT  = 2'd1,
      ST_EDGE_CNT = 2'd2,
      ST_WAITING  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_WAIT    = 2'd1,
      PH_CAPTURE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   level_threshold;
      logic [GAP_W-1:0]     gap_threshold;
      logic [TIMEOUT_W-1:0] timeout_ms;
      logic [LENGTH_W-1:0]  capture_length;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SAMPLE_W-1:0] sample;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic [CODE_W-1:0] path_code;
   } result_type;

endpackage

### hw/rtl/ir_pulse_distance_decoder.sv
// Pulse-distance IR frame decoder.
// req_ channel: one transaction per item; tuser carries the action (start,
//   analog sample, millisecond tick), tdata the 10-bit analog sample.
// rsp_ channel: at most one transaction per item, sent when a frame ends or
//   the wait for signal times out; tuser carries the status, tdata the code.
// csr_ channel: register writes (level threshold, gap threshold, timeout,
//   capture length); always ready, write only while the decoder is idle.
// Throughput: one item per cycle while the result slot is free. An accepted
//   item sits in the input register while compare/count logic updates the
//   frame state, and its result is loaded into the result register as the
//   item leaves the input register, and rsp_tvalid rises once it is loaded.
// Stall: while rsp_tvalid is high and rsp_tready low, the result holds and
//   the held item waits in the input register; req_tready drops once that
//   register is full. Items that give no result still need the slot free.
// Reset: synchronous, active high; clears the frame state to idle, empties
//   both registers and loads the register defaults (25, 15, 200, 500).
module ir_pulse_distance_decoder #(
   parameter int EXPECTED_EDGES = 9
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ird_pkg::REQ_DATA_W-1:0]  req_tdata,   // [9:0] sample
   input  logic [ird_pkg::ACTION_W-1:0]    req_tuser,   // [1:0] action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ird_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [2:0] path_code
   output logic [ird_pkg::STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ird_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ird_pkg::*;

   cfg_type    cfg;
   item_type   in_item;
   item_type   stage_item;
   logic       stage_valid;
   logic       stage_take;
   logic       out_free;
   logic       res_valid;
   result_type res;
   result_type out_res;

   assign csr_ready = 1'b1;

   ird_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Unpack the request
   assign in_item.action = req_tuser;
   assign in_item.sample = req_tdata[SAMPLE_W-1:0];

   ird_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (in_item),
      .stage_valid (stage_valid),
      .stage_item  (stage_item),
      .stage_take  (stage_take)
   );

   // Process the held item when the result slot can take its output
   assign stage_take = stage_valid && out_free;

   ird_frame_core #(
      .EXPECTED_EDGES (EXPECTED_EDGES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_fire (stage_take),
      .item      (stage_item),
      .res_valid (res_valid),
      .res       (res)
   );

   ird_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_valid),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // Pack the response
   assign rsp_tuser = out_res.status;
   assign rsp_tdata = {{(RSP_DATA_W - CODE_W){1'b0}}, out_res.path_code};

endmodule

### hw/rtl/ird_csr_regs.sv
module ird_csr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [ird_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ird_pkg::CSR_DATA_W-1:0]  csr_data,
   output ird_pkg::cfg_type                cfg
);
   import ird_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEVEL_THRESHOLD: cfg_in.level_threshold = csr_data[LEVEL_W-1:0];
            CSR_GAP_THRESHOLD:   cfg_in.gap_threshold   = csr_data[GAP_W-1:0];
            CSR_TIMEOUT_MS:      cfg_in.timeout_ms      = csr_data[TIMEOUT_W-1:0];
            CSR_CAPTURE_LENGTH:  cfg_in.capture_length  = csr_data[LENGTH_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold <= LEVEL_THRESHOLD_RST;
         cfg_ff.gap_threshold   <= GAP_THRESHOLD_RST;
         cfg_ff.timeout_ms      <= TIMEOUT_MS_RST;
         cfg_ff.capture_length  <= CAPTURE_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/ird_in_stage.sv
module ird_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ird_pkg::item_type in_item,
   output logic              stage_valid,
   output ird_pkg::item_type stage_item,
   input  logic              stage_take
);
   import ird_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // Refill when empty or whenever the held transaction leaves this cycle
   assign in_ready = !valid_ff || stage_take;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

### hw/rtl/ird_frame_core.sv
module ird_frame_core #(
   parameter int EXPECTED_EDGES = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  ird_pkg::cfg_type    cfg,
   input  logic                item_fire,
   input  ird_pkg::item_type   item,
   output logic                res_valid,
   output ird_pkg::result_type res
);
   import ird_pkg::*;

   localparam int CNT_W     = $clog2(EXPECTED_EDGES + 2);
   localparam int WAIT_GAPS = (EXPECTED_EDGES > 3) ? EXPECTED_EDGES - 3 : 0;
   localparam logic [CNT_W-1:0] EDGE_CAP  = CNT_W'(EXPECTED_EDGES + 1);
   localparam logic [CNT_W-1:0] EDGE_EXP  = CNT_W'(EXPECTED_EDGES);
   localparam logic [CNT_W-1:0] LAST_GAP  = CNT_W'(EXPECTED_EDGES - 1);
   localparam logic [CNT_W-1:0] WAIT_LIM  = CNT_W'(WAIT_GAPS);
   localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   phase_type               phase_ff,     phase_in;
   logic [TIMEOUT_W-1:0]    elapsed_ff,   elapsed_in;
   logic [LENGTH_W-1:0]     index_ff,     index_in;
   logic                    prev_ff,      prev_in;
   logic [CNT_W-1:0]        edges_ff,     edges_in;
   logic [LENGTH_W-1:0]     last_pos_ff,  last_pos_in;
   logic                    waiting_ff,   waiting_in;
   logic [CODE_W-1:0]       code_ff,      code_in;

   logic                    level;
   logic [TIMEOUT_W-1:0]    elapsed_inc;
   logic [LENGTH_W-1:0]     len;
   logic [LENGTH_W:0]       index_next;
   logic [LENGTH_W-1:0]     gap;
   logic [CNT_W-1:0]        edge_num;
   logic [CNT_W-1:0]        gap_num;
   logic [1:0]              bitpos;
   logic                    gap_one;
   logic                    rising;

   // Per-sample terms
   assign level       = item.sample > cfg.level_threshold;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign len         = (cfg.capture_length == '0) ? LENGTH_W'(1) : cfg.capture_length;
   assign index_next  = {1'b0, index_ff} + 1'b1;
   assign rising      = (index_ff != '0) && level && !prev_ff;
   assign edge_num    = edges_ff + 1'b1;
   assign gap_num     = edge_num - CNT_ONE;
   assign gap         = index_ff - last_pos_ff;
   assign gap_one     = gap >= cfg.gap_threshold;
   assign bitpos      = 2'(LAST_GAP - gap_num);

   // Next state and result
   always_comb begin
      phase_in    = phase_ff;
      elapsed_in  = elapsed_ff;
      index_in    = index_ff;
      prev_in     = prev_ff;
      edges_in    = edges_ff;
      last_pos_in = last_pos_ff;
      waiting_in  = waiting_ff;
      code_in     = code_ff;
      res_valid   = 1'b0;
      res.status    = ST_OK;
      res.path_code = '0;

      if (item_fire) begin
         if (action_type'(item.action) == ACT_START) begin
            // Re-arm and drop any frame in progress
            phase_in    = PH_WAIT;
            elapsed_in  = '0;
            index_in    = '0;
            prev_in     = 1'b0;
            edges_in    = '0;
            last_pos_in = '0;
            waiting_in  = 1'b0;
            code_in     = '0;
         end else begin
            unique case (phase_ff)
               PH_WAIT: begin
                  if (action_type'(item.action) == ACT_TICK) begin
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc > cfg.timeout_ms) begin
                        phase_in   = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_TIMEOUT;
                     end
                  end else if (action_type'(item.action) == ACT_SAMPLE && level) begin
                     phase_in = PH_CAPTURE;
                     index_in = '0;
                     prev_in  = 1'b0;
                  end
               end
               PH_CAPTURE: begin
                  if (action_type'(item.action) == ACT_SAMPLE) begin
                     // Count the edge and classify its gap
                     if (rising && edges_ff < EDGE_CAP) begin
                        edges_in    = edge_num;
                        last_pos_in = index_ff;
                        if (edge_num >= CNT_TWO && edge_num <= EDGE_EXP) begin
                           if (gap_num < WAIT_LIM) begin
                              waiting_in = waiting_ff | gap_one;
                           end else if (gap_one) begin
                              code_in = code_ff | (CODE_W'(1) << bitpos);
                           end
                        end
                     end
                     prev_in = level;
                     if (index_next >= {1'b0, len}) begin
                        // Frame ends: report with precedence
                        phase_in  = PH_IDLE;
                        res_valid = 1'b1;
                        if (edges_in != EDGE_EXP) begin
                           res.status = ST_EDGE_CNT;
                        end else if (waiting_in) begin
                           res.status = ST_WAITING;
                        end else begin
                           res.status    = ST_OK;
                           res.path_code = code_in;
                        end
                     end else begin
                        index_in = index_next[LENGTH_W-1:0];
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         elapsed_ff  <= '0;
         index_ff    <= '0;
         prev_ff     <= 1'b0;
         edges_ff    <= '0;
         last_pos_ff <= '0;
         waiting_ff  <= 1'b0;
         code_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         elapsed_ff  <= elapsed_in;
         index_ff    <= index_in;
         prev_ff     <= prev_in;
         edges_ff    <= edges_in;
         last_pos_ff <= last_pos_in;
         waiting_ff  <= waiting_in;
         code_ff     <= code_in;
      end
   end

endmodule

### hw/rtl/ird_out_stage.sv
module ird_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_load,
   input  ird_pkg::result_type res,
   output logic                out_free,
   output logic                out_valid,
   input  logic                out_ready,
   output ird_pkg::result_type out_res
);
   import ird_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // Slot is free when empty or drained this cycle
   assign out_free = !valid_ff || out_ready;

   always_comb begin
      if (res_load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule
